>>> rtl/segment_pair_clearance_check_defines.svh
// assertion helpers
`ifndef SEGMENT_PAIR_CLEARANCE_CHECK_DEFINES_SVH
`define SEGMENT_PAIR_CLEARANCE_CHECK_DEFINES_SVH
`ifndef SYNTHESIS
`define SCC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCC_ASSERT_IMPL(lbl, ante, cons, msg)
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/scc_pkg.sv
`timescale 1ns / 1ps
package scc_pkg;
    localparam int WIDTH_W    = 20;
    localparam int CLR_W      = 26;
    localparam int CLR_MAX    = 33554431;
    localparam int MINC_RESET = 200;
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHECK = 1'b1;
endpackage

>>> rtl/scc_mul.sv
`timescale 1ns / 1ps
module scc_mul #(
    parameter int MW = 26
) (
    input  logic                   i_clk,
    input  logic signed [MW-1:0]   i_a,
    input  logic signed [MW-1:0]   i_b,
    output logic signed [2*MW-1:0] o_prod
);
    logic signed [2*MW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

>>> rtl/segment_pair_clearance_check.sv
`timescale 1ns / 1ps
// Copper clearance check against one stored reference segment. A load word
// (opcode 0) yields nothing; a check word yields one result. A check on
// another layer or the same nonzero net skips the math and answers with
// clearance 0 and no violation. A full check runs both endpoints through one
// shared registered multiplier, a restoring divider and a 2-bit-per-cycle
// square root over 2*MW-bit values (MW = max(min(COORD_BITS,29)+2,
// T_FRAC_BITS+2)); an endpoint whose projection falls outside the reference
// skips the T_FRAC_BITS divide steps. The input is stalled until the result
// enters the output register, which frees when taken.
`include "segment_pair_clearance_check_defines.svh"
module segment_pair_clearance_check
    import scc_pkg::*;
#(
    parameter int COORD_BITS  = 24,
    parameter int LAYER_BITS  = 6,
    parameter int NET_BITS    = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_opcode,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    input  logic [WIDTH_W-1:0]           i_track_width,
    input  logic [LAYER_BITS-1:0]        i_layer,
    input  logic [NET_BITS-1:0]          i_net_id,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_violation,
    output logic signed [CLR_W-1:0]      o_clearance,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [WIDTH_W-1:0]           i_cfg_data
);
    localparam int CW    = (COORD_BITS > 29) ? 29 : COORD_BITS;
    localparam int MW    = ((CW + 2) > (T_FRAC_BITS + 2)) ? (CW + 2) : (T_FRAC_BITS + 2);
    localparam int PW    = 2 * MW;
    localparam int CNT_W = $clog2(PW);
    localparam int EW    = MW + 28;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_M1, S_M2, S_M3, S_M4, S_M5, S_DIV,
        S_TX, S_TY, S_TE, S_SQ0, S_SQ1, S_SQ2, S_SQRT, S_SDONE
    } t_state;
    typedef enum logic [0:0] { F_RUN, F_OUT } t_fin;

    t_state r_state;
    t_fin   r_fin;

    logic signed [CW-1:0] r_rxs, r_rys, r_rxe, r_rye;
    logic [WIDTH_W-1:0]    r_rw, r_w;
    logic [LAYER_BITS-1:0] r_rlay;
    logic [NET_BITS-1:0]   r_rnet;
    logic [WIDTH_W-1:0]    r_min_clr;

    logic signed [CW-1:0] r_p0x, r_p0y, r_p1x, r_p1y;
    logic                 r_sel, r_skip;
    logic signed [MW-1:0] r_dx, r_dy, r_ux, r_uy, r_ex, r_ey, r_ma, r_mb;
    logic signed [PW-1:0] r_acc, r_len2;
    logic [PW-1:0]        r_rem, r_v, r_res, r_bit;
    logic [T_FRAC_BITS:0] r_t;
    logic [CNT_W-1:0]     r_cnt;
    logic [MW-1:0]        r_d;

    logic signed [PW-1:0] w_prod, w_dot, w_sum2, w_rnd;
    logic [PW-1:0]        w_rem2, w_sq_try;
    logic signed [CW-1:0] w_px, w_py;
    logic [MW-1:0]        w_dmin;
    logic [EW-1:0]        w_dext;
    logic signed [EW-1:0] w_clr;
    logic [WIDTH_W:0]     w_hw;
    logic                 w_in_acc;

    scc_mul #(.MW(MW)) u_mul (
        .i_clk  (i_clk),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .o_prod (w_prod)
    );

    assign o_stall     = (r_state != S_IDLE) || (r_fin == F_OUT);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_px        = r_sel ? r_p1x : r_p0x;
    assign w_py        = r_sel ? r_p1y : r_p0y;
    assign w_dot       = r_acc + w_prod;
    assign w_rnd       = (w_prod + (PW'(1) <<< (T_FRAC_BITS - 1))) >>> T_FRAC_BITS;
    assign w_rem2      = r_rem << 1;
    assign w_sq_try    = r_res + r_bit;
    assign w_sum2      = r_acc + w_prod;
    assign w_dmin      = (r_d < r_res[MW-1:0]) ? r_d : r_res[MW-1:0];

    always_comb begin
        w_dext = EW'(r_d);
        if (w_dext > EW'(2 * CLR_MAX)) begin
            w_dext = EW'(2 * CLR_MAX);
        end
        w_hw  = ({1'b0, r_rw} + {1'b0, r_w} + (WIDTH_W+1)'(1)) >> 1;
        w_clr = $signed(w_dext) - $signed(EW'(w_hw));
        if (w_clr > $signed(EW'(CLR_MAX))) begin
            w_clr = $signed(EW'(CLR_MAX));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fin     <= F_RUN;
            o_valid   <= 1'b0;
            r_rxs     <= '0;
            r_rys     <= '0;
            r_rxe     <= '0;
            r_rye     <= '0;
            r_rw      <= '0;
            r_rlay    <= '0;
            r_rnet    <= '0;
            r_min_clr <= WIDTH_W'(MINC_RESET);
        end else begin
            if (i_cfg_valid) begin
                r_min_clr <= i_cfg_data;
            end
            if (o_valid && !i_stall && r_fin != F_OUT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (r_fin == F_OUT) begin
                        if (!o_valid || !i_stall) begin
                            o_valid <= 1'b1;
                            r_fin   <= F_RUN;
                            if (r_skip) begin
                                o_violation <= 1'b0;
                                o_clearance <= '0;
                            end else begin
                                o_clearance <= w_clr[CLR_W-1:0];
                                o_violation <= (w_clr > 0) &&
                                               (w_clr < $signed(EW'(r_min_clr)));
                            end
                        end
                    end else if (w_in_acc) begin
                        if (i_opcode == OP_LOAD) begin
                            r_rxs  <= i_x_start[CW-1:0];
                            r_rys  <= i_y_start[CW-1:0];
                            r_rxe  <= i_x_end[CW-1:0];
                            r_rye  <= i_y_end[CW-1:0];
                            r_rw   <= i_track_width;
                            r_rlay <= i_layer;
                            r_rnet <= i_net_id;
                        end else begin
                            r_p0x <= i_x_start[CW-1:0];
                            r_p0y <= i_y_start[CW-1:0];
                            r_p1x <= i_x_end[CW-1:0];
                            r_p1y <= i_y_end[CW-1:0];
                            r_w   <= i_track_width;
                            r_sel <= 1'b0;
                            if (i_layer != r_rlay || (i_net_id != '0 && r_rnet != '0 &&
                                                      i_net_id == r_rnet)) begin
                                r_skip <= 1'b1;
                                r_fin  <= F_OUT;
                            end else begin
                                r_skip  <= 1'b0;
                                r_state <= S_PREP;
                            end
                        end
                    end
                end
                S_PREP: begin
                    r_dx    <= MW'(r_rxe) - MW'(r_rxs);
                    r_dy    <= MW'(r_rye) - MW'(r_rys);
                    r_ux    <= MW'(w_px) - MW'(r_rxs);
                    r_uy    <= MW'(w_py) - MW'(r_rys);
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_ma    <= r_dx;
                    r_mb    <= r_dx;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_ma    <= r_dy;
                    r_mb    <= r_dy;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_acc   <= w_prod;
                    r_ma    <= r_ux;
                    r_mb    <= r_dx;
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_len2  <= r_acc + w_prod;
                    r_ma    <= r_uy;
                    r_mb    <= r_dy;
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_acc   <= w_prod;
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                    r_t     <= '0;
                end
                S_DIV: begin
                    if (r_cnt == '0 && r_len2 == '0) begin
                        r_ex    <= -r_ux;
                        r_ey    <= -r_uy;
                        r_state <= S_SQ0;
                    end else if (r_cnt == '0 && w_dot <= 0) begin
                        r_t     <= '0;
                        r_state <= S_TX;
                    end else if (r_cnt == '0 && w_dot >= r_len2) begin
                        r_t     <= (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
                        r_state <= S_TX;
                    end else if (r_cnt == '0) begin
                        r_rem <= w_dot;
                        r_cnt <= CNT_W'(1);
                    end else begin
                        if (w_rem2 >= r_len2) begin
                            r_rem <= w_rem2 - r_len2;
                            r_t   <= {r_t[T_FRAC_BITS-1:0], 1'b1};
                        end else begin
                            r_rem <= w_rem2;
                            r_t   <= {r_t[T_FRAC_BITS-1:0], 1'b0};
                        end
                        r_cnt <= r_cnt + CNT_W'(1);
                        if (r_cnt == CNT_W'(T_FRAC_BITS)) begin
                            r_state <= S_TX;
                        end
                    end
                end
                S_TX: begin
                    r_ma    <= MW'(r_t);
                    r_mb    <= r_dx;
                    r_state <= S_TY;
                end
                S_TY: begin
                    r_mb    <= r_dy;
                    r_state <= S_TE;
                end
                S_TE: begin
                    r_ex    <= -r_ux + w_rnd[MW-1:0];
                    r_state <= S_SQ0;
                end
                S_SQ0: begin
                    if (r_len2 != '0) begin
                        r_ey <= -r_uy + w_rnd[MW-1:0];
                    end
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_ma    <= r_ex;
                    r_mb    <= r_ex;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_ma    <= r_ey;
                    r_mb    <= r_ey;
                    r_res   <= '0;
                    r_bit   <= PW'(1) << (PW - 2);
                    r_state <= S_SQRT;
                    r_cnt   <= '0;
                end
                S_SQRT: begin
                    // ex^2 arrives first, then ey^2
                    if (r_cnt == '0) begin
                        r_acc <= w_prod;
                        r_cnt <= CNT_W'(1);
                    end else if (r_cnt == CNT_W'(1)) begin
                        r_v   <= w_sum2;
                        r_cnt <= CNT_W'(2);
                    end else begin
                        if (r_v >= w_sq_try) begin
                            r_v   <= r_v - w_sq_try;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                        if (r_bit[0]) begin
                            r_state <= S_SDONE;
                        end
                    end
                end
                S_SDONE: begin
                    if (!r_sel) begin
                        r_d     <= r_res[MW-1:0];
                        r_sel   <= 1'b1;
                        r_state <= S_PREP;
                    end else begin
                        r_d     <= w_dmin;
                        r_fin   <= F_OUT;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SCC_ASSERT_NEXT(a_check_busy, w_in_acc && i_opcode == OP_CHECK, o_stall, "check not held")
    `SCC_ASSERT_IMPL(a_viol_pos, o_valid && o_violation, o_clearance > 0, "violation at clr <= 0")
    `SCC_ASSERT_IMPL(a_busy_state, r_state != S_IDLE, o_stall, "input open while busy")
endmodule
